// ===== rtl/wave_equation_stencil_2d_defines.svh =====
// ----------------------------------------------------------------------------
// wave equation stencil assertion macros
// shared property forms for the stencil checker
// ----------------------------------------------------------------------------
`ifndef WAVE_EQUATION_STENCIL_2D_DEFINES_SVH
`define WAVE_EQUATION_STENCIL_2D_DEFINES_SVH

// same-cycle implication
`define WES_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("wes checker: property failed");

// next-cycle implication
`define WES_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("wes checker: property failed");

`endif

// ===== rtl/wes_pkg.sv =====
// ----------------------------------------------------------------------------
// wes_pkg
// types and constants of the 2d wave equation stencil
// ----------------------------------------------------------------------------
`default_nettype none

package wes_pkg;

	localparam int SAMPLE_W    = 32;
	localparam int ROW_W       = 16;
	localparam int COL_OUT_W   = 12;
	localparam int LEN_CFG_W   = 13;
	localparam int COEF_W      = 25;
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 25;

	// laplacian sum, 2u - p, product halves, scaled terms, final sum
	localparam int LAP_W   = 35;
	localparam int TWOU_W  = 34;
	localparam int LO_W    = 18;
	localparam int HI_W    = LAP_W - LO_W;
	localparam int PLO_W   = LO_W + COEF_W;
	localparam int PHI_W   = HI_W + COEF_W + 1;
	localparam int PROD_W  = LAP_W + COEF_W + 1;
	localparam int FRAC_W  = 24;
	localparam int TERM_W  = 36;
	localparam int TOTAL_W = 38;

	localparam logic [LEN_CFG_W-1:0] ROW_LENGTH_MIN   = 13'd3;
	localparam logic [ROW_W-1:0]     ROW_COUNT_MIN    = 16'd3;
	localparam logic [LEN_CFG_W-1:0] ROW_LENGTH_RESET = 13'd64;
	localparam logic [ROW_W-1:0]     ROW_COUNT_RESET  = 16'd64;
	localparam logic [COEF_W-1:0]    COEF_RESET       = 25'd1678;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_ROW_LENGTH,
		REG_ROW_COUNT,
		REG_COEF_X,
		REG_COEF_Y
	} wes_reg_t;

	// per-item bookkeeping that travels alongside the arithmetic
	typedef struct packed {
		logic                 has_first;
		logic                 has_second;
		logic                 inner;
		logic                 frame_end;
		logic [ROW_W-1:0]     row;
		logic [COL_OUT_W-1:0] col;
	} wes_tag_t;

endpackage

`default_nettype wire

// ===== rtl/wes_ram.sv =====
// ----------------------------------------------------------------------------
// wes_ram
// simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module wes_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4096
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

// ===== rtl/wes_cell.sv =====
// ----------------------------------------------------------------------------
// wes_cell
// one sample cell of the horizontal window chain
// ----------------------------------------------------------------------------
`default_nettype none

module wes_cell #(
	parameter int WIDTH = 32
) (
	input  wire logic             clk,
	input  wire logic             shift,
	input  wire logic [WIDTH-1:0] d,
	output logic      [WIDTH-1:0] q
);

	logic [WIDTH-1:0] sample_q;

	always_ff @(posedge clk) begin
		if (shift) begin
			sample_q <= d;
		end
	end

	assign q = sample_q;

endmodule

`default_nettype wire

// ===== rtl/wes_update.sv =====
// ----------------------------------------------------------------------------
// wes_update
// four-stage leapfrog update: laplacians, split products, scaling, saturation
// ----------------------------------------------------------------------------
`default_nettype none

module wes_update import wes_pkg::*; (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       en,
	input  wire logic                       in_valid,
	input  wire wes_tag_t                   in_tag,
	input  wire logic signed [SAMPLE_W-1:0] left,
	input  wire logic signed [SAMPLE_W-1:0] center,
	input  wire logic signed [SAMPLE_W-1:0] right,
	input  wire logic signed [SAMPLE_W-1:0] up,
	input  wire logic signed [SAMPLE_W-1:0] down,
	input  wire logic signed [SAMPLE_W-1:0] prev,
	input  wire logic        [COEF_W-1:0]   coef_x,
	input  wire logic        [COEF_W-1:0]   coef_y,
	output logic                            out_valid,
	output wes_tag_t                        out_tag,
	output logic signed      [SAMPLE_W-1:0] out_value
);

	logic                       v_s1, v_s2, v_s3, v_s4;
	wes_tag_t                   tag_s1, tag_s2, tag_s3, tag_s4;
	logic signed [LAP_W-1:0]    lx_s1, ly_s1;
	logic signed [TWOU_W-1:0]   twou_s1, twou_s2, twou_s3;
	logic        [PLO_W-1:0]    px_lo_s2, py_lo_s2;
	logic signed [PHI_W-1:0]    px_hi_s2, py_hi_s2;
	logic signed [TERM_W-1:0]   tx_s3, ty_s3;
	logic signed [SAMPLE_W-1:0] value_s4;

	logic [PROD_W-1:0]          prod_x, prod_y;
	logic signed [TOTAL_W-1:0]  total;
	logic signed [SAMPLE_W-1:0] total_sat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// recombine the split products, floor shift by the coefficient fraction
	always_comb begin
		prod_x = (PROD_W'(px_hi_s2) <<< LO_W) + PROD_W'(px_lo_s2);
		prod_y = (PROD_W'(py_hi_s2) <<< LO_W) + PROD_W'(py_lo_s2);
	end

	always_comb begin
		total = TOTAL_W'(twou_s3) + TOTAL_W'(tx_s3) + TOTAL_W'(ty_s3);
		if (total[TOTAL_W-1:SAMPLE_W-1] == '0 || total[TOTAL_W-1:SAMPLE_W-1] == '1) begin
			total_sat = total[SAMPLE_W-1:0];
		end else if (total[TOTAL_W-1]) begin
			total_sat = {1'b1, {(SAMPLE_W-1){1'b0}}};
		end else begin
			total_sat = {1'b0, {(SAMPLE_W-1){1'b1}}};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tag_s1   <= in_tag;
			lx_s1    <= LAP_W'(left) - (LAP_W'(center) <<< 1) + LAP_W'(right);
			ly_s1    <= LAP_W'(up) - (LAP_W'(center) <<< 1) + LAP_W'(down);
			twou_s1  <= (TWOU_W'(center) <<< 1) - TWOU_W'(prev);

			tag_s2   <= tag_s1;
			twou_s2  <= twou_s1;
			px_lo_s2 <= PLO_W'(lx_s1[LO_W-1:0]) * PLO_W'(coef_x);
			py_lo_s2 <= PLO_W'(ly_s1[LO_W-1:0]) * PLO_W'(coef_y);
			px_hi_s2 <= $signed(lx_s1[LAP_W-1:LO_W]) * $signed({1'b0, coef_x});
			py_hi_s2 <= $signed(ly_s1[LAP_W-1:LO_W]) * $signed({1'b0, coef_y});

			tag_s3   <= tag_s2;
			twou_s3  <= twou_s2;
			tx_s3    <= $signed(prod_x[PROD_W-2:FRAC_W]);
			ty_s3    <= $signed(prod_y[PROD_W-2:FRAC_W]);

			tag_s4   <= tag_s3;
			value_s4 <= tag_s3.inner ? total_sat : '0;
		end
	end

	assign out_valid = v_s4;
	assign out_tag   = tag_s4;
	assign out_value = value_s4;

endmodule

`default_nettype wire

// ===== rtl/wave_equation_stencil_2d.sv =====
// ----------------------------------------------------------------------------
// wave_equation_stencil_2d
// one leapfrog time step of the 2d wave equation on a raster stream
// ----------------------------------------------------------------------------
// Takes one grid point per clock while s_tready is high (current and previous
// field) in raster order and returns the next field one row behind: each item
// accepted past the first row leaves the five-point update of the point one
// row up, and items of the last row also leave their own (zero) frame point,
// so the last row is held back by the single result port. Results pass the
// update pipeline registers before the output register. Neighbors come from
// three line memories (upper, center, previous) addressed one or two
// columns ahead of the input, and a two-cell chain that slides the center row
// past the window. Line memories need no clearing pass; rows before the first
// full one are never used. Writing row_length or row_count restarts the frame;
// write configuration only while no item is in flight.
`default_nettype none

module wave_equation_stencil_2d import wes_pkg::*; #(
	parameter int MAX_ROW_LENGTH = 4096
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   s_tvalid,
	output logic                        s_tready,
	input  wire logic [63:0]            s_tdata,   // cur_sample, prev_sample
	output logic                        m_tvalid,
	input  wire logic                   m_tready,
	output logic      [63:0]            m_tdata,   // next_sample, out_row, out_col, zero pad
	output logic                        m_tlast,   // frame_end
	output logic                        m_tuser,   // last_of_item
	input  wire logic                   cfg_valid,
	output logic                        cfg_ready,
	input  wire logic [CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

	localparam int COL_W = $clog2(MAX_ROW_LENGTH);
	localparam int LEN_W = $clog2(MAX_ROW_LENGTH + 1);

	logic [LEN_CFG_W-1:0] row_length_q;
	logic [ROW_W-1:0]     row_count_q;
	logic [COEF_W-1:0]    coef_x_q, coef_y_q;
	logic                 cfg_wr;
	wes_reg_t             cfg_sel;

	logic [LEN_W-1:0]     len_eff;
	logic [LEN_W:0]       len_ext, col_p1, col_p2;
	logic [ROW_W-1:0]     rows_eff;
	logic [COL_W-1:0]     col_q, rd_addr_near, rd_addr_far;
	logic [ROW_W-1:0]     row_q;
	logic                 col_last, row_last, accept;

	logic signed [SAMPLE_W-1:0] cur_sample, prev_sample;
	logic signed [SAMPLE_W-1:0] center_rd, upper_rd, prev_rd, mid_q, left_q;

	wes_tag_t                   in_tag, tag_s4;
	logic                       v_s4;
	logic signed [SAMPLE_W-1:0] value_s4;

	logic                 first_done_q, pick_first, has_any, out_free, move, last_pick, adv;
	logic                 m_tvalid_q, m_tlast_q, m_tuser_q;
	logic [SAMPLE_W-1:0]  out_value_q;
	logic [ROW_W-1:0]     out_row_q;
	logic [COL_OUT_W-1:0] out_col_q;

	assign cur_sample  = s_tdata[31:0];
	assign prev_sample = s_tdata[63:32];

	// configuration
	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid && cfg_ready;
	assign cfg_sel   = wes_reg_t'(cfg_index);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_length_q <= ROW_LENGTH_RESET;
			row_count_q  <= ROW_COUNT_RESET;
			coef_x_q     <= COEF_RESET;
			coef_y_q     <= COEF_RESET;
		end else if (cfg_wr) begin
			case (cfg_sel)
				REG_ROW_LENGTH: row_length_q <= cfg_data[LEN_CFG_W-1:0];
				REG_ROW_COUNT:  row_count_q  <= cfg_data[ROW_W-1:0];
				REG_COEF_X:     coef_x_q     <= cfg_data[COEF_W-1:0];
				REG_COEF_Y:     coef_y_q     <= cfg_data[COEF_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// effective geometry
	always_comb begin
		if (row_length_q < ROW_LENGTH_MIN) begin
			len_eff = LEN_W'(ROW_LENGTH_MIN);
		end else if (32'(row_length_q) > 32'(MAX_ROW_LENGTH)) begin
			len_eff = LEN_W'(MAX_ROW_LENGTH);
		end else begin
			len_eff = LEN_W'(row_length_q);
		end
		rows_eff = (row_count_q < ROW_COUNT_MIN) ? ROW_COUNT_MIN : row_count_q;
	end

	assign len_ext  = (LEN_W+1)'(len_eff);
	assign col_p1   = (LEN_W+1)'(col_q) + 1'b1;
	assign col_p2   = col_p1 + 1'b1;
	assign col_last = col_p1 >= len_ext;
	assign row_last = (17'(row_q) + 17'd1) >= 17'(rows_eff);

	// memories are read ahead: upper and previous for the next column,
	// center two columns ahead to feed the window chain
	assign rd_addr_near = col_last ? '0 : COL_W'(col_p1);
	assign rd_addr_far  = (col_p2 >= len_ext) ? COL_W'(col_p2 - len_ext) : COL_W'(col_p2);

	assign accept   = s_tvalid && s_tready;
	assign s_tready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (cfg_wr && (cfg_sel == REG_ROW_LENGTH || cfg_sel == REG_ROW_COUNT)) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (col_last) begin
				col_q <= '0;
				row_q <= row_last ? '0 : row_q + 16'd1;
			end else begin
				col_q <= col_q + 1'b1;
			end
		end
	end

	wes_ram #(.WIDTH(SAMPLE_W), .DEPTH(MAX_ROW_LENGTH)) u_center_ram (
		.clk     (clk),
		.wr_en   (accept),
		.wr_addr (col_q),
		.wr_data (cur_sample),
		.rd_en   (accept),
		.rd_addr (rd_addr_far),
		.rd_data (center_rd)
	);

	wes_ram #(.WIDTH(SAMPLE_W), .DEPTH(MAX_ROW_LENGTH)) u_upper_ram (
		.clk     (clk),
		.wr_en   (accept),
		.wr_addr (col_q),
		.wr_data (mid_q),
		.rd_en   (accept),
		.rd_addr (rd_addr_near),
		.rd_data (upper_rd)
	);

	wes_ram #(.WIDTH(SAMPLE_W), .DEPTH(MAX_ROW_LENGTH)) u_prev_ram (
		.clk     (clk),
		.wr_en   (accept),
		.wr_addr (col_q),
		.wr_data (prev_sample),
		.rd_en   (accept),
		.rd_addr (rd_addr_near),
		.rd_data (prev_rd)
	);

	// window chain: right (ram output) -> center -> left
	wes_cell #(.WIDTH(SAMPLE_W)) u_cell_mid (
		.clk   (clk),
		.shift (accept),
		.d     (center_rd),
		.q     (mid_q)
	);

	wes_cell #(.WIDTH(SAMPLE_W)) u_cell_left (
		.clk   (clk),
		.shift (accept),
		.d     (mid_q),
		.q     (left_q)
	);

	always_comb begin
		in_tag.has_first  = row_q != '0;
		in_tag.has_second = row_last;
		in_tag.inner      = row_q >= 16'd2 && col_q != '0 && col_p2 <= len_ext;
		in_tag.frame_end  = row_last && col_last;
		in_tag.row        = row_q;
		in_tag.col        = COL_OUT_W'(col_q);
	end

	wes_update u_update (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (accept),
		.in_tag    (in_tag),
		.left      (left_q),
		.center    (mid_q),
		.right     (center_rd),
		.up        (upper_rd),
		.down      (cur_sample),
		.prev      (prev_rd),
		.coef_x    (coef_x_q),
		.coef_y    (coef_y_q),
		.out_valid (v_s4),
		.out_tag   (tag_s4),
		.out_value (value_s4)
	);

	// hand the stencil point, then the last-row point, to the output register
	always_comb begin
		pick_first = tag_s4.has_first && !first_done_q;
		has_any    = tag_s4.has_first || tag_s4.has_second;
		out_free   = !m_tvalid_q || m_tready;
		move       = v_s4 && has_any && out_free;
		last_pick  = pick_first ? !tag_s4.has_second : 1'b1;
		adv        = !v_s4 || !has_any || (move && last_pick);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_done_q <= 1'b0;
			m_tvalid_q   <= 1'b0;
		end else begin
			if (move && pick_first && !last_pick) begin
				first_done_q <= 1'b1;
			end else if (adv) begin
				first_done_q <= 1'b0;
			end
			if (move) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (move) begin
			out_value_q <= pick_first ? value_s4 : '0;
			out_row_q   <= pick_first ? tag_s4.row - 16'd1 : tag_s4.row;
			out_col_q   <= tag_s4.col;
			m_tlast_q   <= pick_first ? 1'b0 : tag_s4.frame_end;
			m_tuser_q   <= last_pick;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {4'd0, out_col_q, out_row_q, out_value_q};
	assign m_tlast  = m_tlast_q;
	assign m_tuser  = m_tuser_q;

endmodule

`default_nettype wire

// ===== rtl/wes_checker.sv =====
// ----------------------------------------------------------------------------
// wes_checker
// port-level checks of the wave equation stencil, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "wave_equation_stencil_2d_defines.svh"

module wes_checker import wes_pkg::*; (
	input wire logic                   clk,
	input wire logic                   arst_n,
	input wire logic                   s_tvalid,
	input wire logic                   s_tready,
	input wire logic [63:0]            s_tdata,
	input wire logic                   m_tvalid,
	input wire logic                   m_tready,
	input wire logic [63:0]            m_tdata,
	input wire logic                   m_tlast,
	input wire logic                   m_tuser,
	input wire logic                   cfg_valid,
	input wire logic                   cfg_ready,
	input wire logic [CFG_INDEX_W-1:0] cfg_index,
	input wire logic [CFG_DATA_W-1:0]  cfg_data
);

	// stalled result holds
	`WES_ASSERT_NXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast) && $stable(m_tuser))

	// the frame end is always the last result of its item
	`WES_ASSERT_IMP(a_end_is_last, clk, arst_n, m_tvalid && m_tlast, m_tuser)

	// frame points are held at zero
	`WES_ASSERT_IMP(a_end_zero, clk, arst_n, m_tvalid && m_tlast, m_tdata[31:0] == 32'd0)
	`WES_ASSERT_IMP(a_edge_zero, clk, arst_n, m_tvalid && (m_tdata[47:32] == 16'd0 || m_tdata[59:48] == 12'd0), m_tdata[31:0] == 32'd0)

	// padding above the fields stays clear
	`WES_ASSERT_IMP(a_pad_zero, clk, arst_n, m_tvalid, m_tdata[63:60] == 4'd0)

endmodule

bind wave_equation_stencil_2d wes_checker u_wes_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.s_tvalid  (s_tvalid),
	.s_tready  (s_tready),
	.s_tdata   (s_tdata),
	.m_tvalid  (m_tvalid),
	.m_tready  (m_tready),
	.m_tdata   (m_tdata),
	.m_tlast   (m_tlast),
	.m_tuser   (m_tuser),
	.cfg_valid (cfg_valid),
	.cfg_ready (cfg_ready),
	.cfg_index (cfg_index),
	.cfg_data  (cfg_data)
);

`default_nettype wire
